// ===== design/lrufr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrufr_pkg
// Shared constants for the LRU frame replacer: field widths, operation codes,
// configuration register map and reset values.
// ----------------------------------------------------------------------------
package lrufr_pkg;

    localparam int KIND_W       = 2;
    localparam int FRAME_W      = 6;
    localparam int COUNT_W      = 7;
    localparam int LIMIT_W      = 7;
    localparam int FRAME_SPAN   = 2 ** FRAME_W;
    localparam int NUM_FRAMES_DEF = 64;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_VICTIM = 2'd0;
    localparam t_kind KIND_PIN    = 2'd1;
    localparam t_kind KIND_UNPIN  = 2'd2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_LIMIT = 3'd0;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET      = 7'd64;

endpackage

// ===== design/lrufr_ram.sv =====
// ----------------------------------------------------------------------------
// lrufr_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lrufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/lrufr_apb.sv =====
// ----------------------------------------------------------------------------
// lrufr_apb
// APB-style configuration port holding the frame limit register.
// ----------------------------------------------------------------------------
module lrufr_apb (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lrufr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lrufr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lrufr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic [lrufr_pkg::LIMIT_W-1:0]       o_frame_limit
);

    logic [lrufr_pkg::LIMIT_W-1:0] r_frame_limit;
    logic                          hit_limit;

    assign hit_limit = (paddr == lrufr_pkg::ADDR_FRAME_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= lrufr_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && hit_limit) begin
            r_frame_limit <= pwdata[lrufr_pkg::LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (hit_limit) begin
            prdata = {{(lrufr_pkg::APB_DATA_W - lrufr_pkg::LIMIT_W){1'b0}}, r_frame_limit};
        end
    end

    assign pready        = 1'b1;
    assign o_frame_limit = r_frame_limit;

endmodule

// ===== design/lru_frame_replacer.sv =====
// ----------------------------------------------------------------------------
// lru_frame_replacer
// Steps: a no-op goes straight to result; a victim or pin that unlinks
//   passes through take, a plain unpin through put, and an unpin that first
//   drops the newest entry through take then put. One request in flight at a
//   time, held by output stall; RAM steps: read, neighbor write-back, insert.
// Reset (synchronous, active low) empties the list and sets the limit to 64.
// ----------------------------------------------------------------------------
module lru_frame_replacer #(
    parameter int NUM_FRAMES = lrufr_pkg::NUM_FRAMES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lrufr_pkg::KIND_W-1:0]     i_kind,
    input  logic [lrufr_pkg::FRAME_W-1:0]    i_frame,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found,
    output logic [lrufr_pkg::FRAME_W-1:0]    o_victim_frame,
    output logic [lrufr_pkg::COUNT_W-1:0]    o_entry_count,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lrufr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lrufr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lrufr_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int LISTED_N = (NUM_FRAMES < lrufr_pkg::FRAME_SPAN) ?
                              NUM_FRAMES : lrufr_pkg::FRAME_SPAN;
    localparam int LW  = $clog2(LISTED_N);
    localparam int FXW = (FW > lrufr_pkg::FRAME_W) ? FW : lrufr_pkg::FRAME_W;
    localparam int CXW = (CW > lrufr_pkg::COUNT_W) ? CW : lrufr_pkg::COUNT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TAKE   = 2'd1;
    localparam logic [1:0] ST_PUT    = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [FW-1:0]       r_newest, n_newest;
    logic [FW-1:0]       r_oldest, n_oldest;
    logic [CW-1:0]       r_count, n_count;
    logic [LISTED_N-1:0] r_listed, n_listed;
    logic [FW-1:0]       r_tf, r_fi;
    logic                r_found, r_put;
    logic                r_out_valid, n_out_valid;
    logic                r_out_found;
    logic [lrufr_pkg::FRAME_W-1:0] r_out_victim;
    logic [lrufr_pkg::COUNT_W-1:0] r_out_count;

    logic [lrufr_pkg::LIMIT_W-1:0] frame_limit;

    logic          nl_we, ol_we;
    logic [FW-1:0] nl_waddr, ol_waddr, nl_wdata, ol_wdata;
    logic [FW-1:0] nl_rdata, ol_rdata;

    logic [FXW-1:0] in_frame_x;
    logic [FW-1:0]  in_fi;
    logic           in_ok, in_listed;
    logic [CXW-1:0] cnt_x, lim_x;
    logic           cnt_nz, at_limit;
    logic           accept, out_free, load_out;
    logic [FW-1:0]  sel_tf;
    logic           sel_take, sel_put, sel_found;
    logic [CW-1:0]  take_cnt;
    logic [FXW-1:0] tf_x;

    lrufr_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_frame_limit (frame_limit)
    );

    lrufr_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_newer_ram (
        .i_clk   (i_clk),
        .i_we    (nl_we),
        .i_waddr (nl_waddr),
        .i_wdata (nl_wdata),
        .i_raddr (sel_tf),
        .o_rdata (nl_rdata)
    );

    lrufr_ram #(.WIDTH(FW), .DEPTH(NUM_FRAMES)) u_older_ram (
        .i_clk   (i_clk),
        .i_we    (ol_we),
        .i_waddr (ol_waddr),
        .i_wdata (ol_wdata),
        .i_raddr (sel_tf),
        .o_rdata (ol_rdata)
    );

    assign in_frame_x = FXW'(i_frame);
    assign in_fi      = in_frame_x[FW-1:0];
    assign in_ok      = (32'(i_frame) < NUM_FRAMES);
    assign in_listed  = r_listed[i_frame[LW-1:0]];
    assign cnt_x      = CXW'(r_count);
    assign lim_x      = CXW'(frame_limit);
    assign cnt_nz     = (r_count != '0);
    assign at_limit   = (cnt_x >= lim_x);
    assign take_cnt   = cnt_nz ? (r_count - CW'(1)) : '0;
    assign tf_x       = FXW'(r_tf);

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_out   = (r_state == ST_RESULT) && out_free;

    // decode the request into a target frame and the steps it needs
    always_comb begin
        sel_tf    = r_oldest;
        sel_take  = 1'b0;
        sel_put   = 1'b0;
        sel_found = 1'b0;
        unique case (i_kind)
            lrufr_pkg::KIND_VICTIM: begin
                sel_tf    = r_oldest;
                sel_take  = cnt_nz;
                sel_found = cnt_nz;
            end
            lrufr_pkg::KIND_PIN: begin
                sel_tf   = in_fi;
                sel_take = in_ok && in_listed;
            end
            lrufr_pkg::KIND_UNPIN: begin
                sel_tf   = r_newest;
                sel_put  = in_ok && !in_listed;
                sel_take = in_ok && !in_listed && cnt_nz && at_limit;
            end
            default: begin
                sel_tf = r_oldest;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_newest = r_newest;
        n_oldest = r_oldest;
        n_count  = r_count;
        n_listed = r_listed;
        nl_we    = 1'b0;
        nl_waddr = r_fi;
        nl_wdata = r_fi;
        ol_we    = 1'b0;
        ol_waddr = r_fi;
        ol_wdata = r_fi;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (sel_take) begin
                        n_state = ST_TAKE;
                    end else if (sel_put) begin
                        n_state = ST_PUT;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_TAKE: begin
                // unlink: nl_rdata is the newer neighbor, ol_rdata the older
                if (r_tf == r_newest) begin
                    n_newest = ol_rdata;
                end else begin
                    ol_we    = 1'b1;
                    ol_waddr = nl_rdata;
                    ol_wdata = ol_rdata;
                end
                if (r_tf == r_oldest) begin
                    n_oldest = nl_rdata;
                end else begin
                    nl_we    = 1'b1;
                    nl_waddr = ol_rdata;
                    nl_wdata = nl_rdata;
                end
                n_listed[r_tf[LW-1:0]] = 1'b0;
                n_count = take_cnt;
                if (take_cnt == '0) begin
                    n_newest = '0;
                    n_oldest = '0;
                end
                n_state = r_put ? ST_PUT : ST_RESULT;
            end
            ST_PUT: begin
                ol_we    = 1'b1;
                ol_waddr = r_fi;
                if (cnt_nz) begin
                    nl_we    = 1'b1;
                    nl_waddr = r_newest;
                    nl_wdata = r_fi;
                    ol_wdata = r_newest;
                end else begin
                    ol_wdata = r_fi;
                    n_oldest = r_fi;
                end
                n_newest = r_fi;
                n_listed[r_fi[LW-1:0]] = 1'b1;
                n_count  = r_count + CW'(1);
                n_state  = ST_RESULT;
            end
            ST_RESULT: begin
                // finish the insert: the new newest links to itself
                nl_we    = r_put;
                nl_waddr = r_fi;
                nl_wdata = r_fi;
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_newest    <= '0;
            r_oldest    <= '0;
            r_count     <= '0;
            r_listed    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_newest    <= n_newest;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_listed    <= n_listed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tf    <= sel_tf;
            r_fi    <= in_fi;
            r_found <= sel_found;
            r_put   <= sel_put;
        end
        if (load_out) begin
            r_out_found  <= r_found;
            r_out_victim <= r_found ? tf_x[lrufr_pkg::FRAME_W-1:0] : '0;
            r_out_count  <= cnt_x[lrufr_pkg::COUNT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_victim_frame = r_out_victim;
    assign o_entry_count  = r_out_count;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_FRAMES))
        else $error("entry count exceeds frame count");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_newest == '0 && r_oldest == '0))
        else $error("empty list with nonzero ends");

    a_listed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_listed) == 32'(r_count))
        else $error("listed flags disagree with entry count");

    a_out_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_RESULT)
        else $error("result raised outside result state");
`endif

endmodule

// ===== dv/lru_frame_replacer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_frame_replacer_test
// Self-checking bench for the LRU frame replacer. A tracker class mirrors the
// newest-first frame list with its own links and predicts found, victim frame
// and entry count for every accepted request. Stimulus runs through several
// frame_limit settings, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module lru_frame_replacer_test;

    localparam lrufr_pkg::t_kind KIND_UNUSED = 2'd3;
    localparam int               NUM_PHASES  = 8;

    typedef struct packed {
        logic                          found;
        logic [lrufr_pkg::FRAME_W-1:0] victim;
        logic [lrufr_pkg::COUNT_W-1:0] count;
    } t_reply;

    class lru_list_tracker;
        bit                            listed   [lrufr_pkg::FRAME_SPAN];
        logic [lrufr_pkg::FRAME_W-1:0] newer_of [lrufr_pkg::FRAME_SPAN];
        logic [lrufr_pkg::FRAME_W-1:0] older_of [lrufr_pkg::FRAME_SPAN];
        logic [lrufr_pkg::FRAME_W-1:0] newest_frame;
        logic [lrufr_pkg::FRAME_W-1:0] oldest_frame;
        int unsigned                   depth;
        int unsigned                   limit;
        t_reply                        replies_due [$];
        int                            mismatches;

        function new();
            foreach (listed[i]) begin
                listed[i]   = 1'b0;
                newer_of[i] = '0;
                older_of[i] = '0;
            end
            newest_frame = '0;
            oldest_frame = '0;
            depth        = 0;
            limit        = 32'(lrufr_pkg::LIMIT_RESET);
            mismatches   = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void report(string field, logic [31:0] exp_val, logic [31:0] act_val);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, field, exp_val, act_val);
        endfunction

        function void unlink(logic [lrufr_pkg::FRAME_W-1:0] f);
            logic [lrufr_pkg::FRAME_W-1:0] nw;
            logic [lrufr_pkg::FRAME_W-1:0] od;
            nw = newer_of[f];
            od = older_of[f];
            if (f == newest_frame) newest_frame = od;
            else older_of[nw] = od;
            if (f == oldest_frame) oldest_frame = nw;
            else newer_of[od] = nw;
            listed[f] = 1'b0;
            if (depth > 0) depth--;
            if (depth == 0) begin
                newest_frame = '0;
                oldest_frame = '0;
            end
        endfunction

        function void link_newest(logic [lrufr_pkg::FRAME_W-1:0] f);
            if (depth == 0) begin
                oldest_frame = f;
                older_of[f]  = f;
            end else begin
                newer_of[newest_frame] = f;
                older_of[f]            = newest_frame;
            end
            newer_of[f]  = f;
            newest_frame = f;
            listed[f]    = 1'b1;
            depth++;
        endfunction

        function void note_request(lrufr_pkg::t_kind kind,
                                   logic [lrufr_pkg::FRAME_W-1:0] f);
            t_reply r;
            r = '0;
            case (kind)
                lrufr_pkg::KIND_VICTIM: begin
                    if (depth > 0) begin
                        r.found  = 1'b1;
                        r.victim = oldest_frame;
                        unlink(oldest_frame);
                    end
                end
                lrufr_pkg::KIND_PIN: begin
                    if (listed[f]) unlink(f);
                end
                lrufr_pkg::KIND_UNPIN: begin
                    if (!listed[f]) begin
                        if (depth > 0 && depth >= limit) unlink(newest_frame);
                        link_newest(f);
                    end
                end
                default: begin
                end
            endcase
            r.count = depth[lrufr_pkg::COUNT_W-1:0];
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic found, logic [lrufr_pkg::FRAME_W-1:0] victim,
                                  logic [lrufr_pkg::COUNT_W-1:0] count);
            t_reply e;
            if (replies_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected reply, expected none actual %0d/%0d/%0d",
                         $time, found, victim, count);
                return;
            end
            e = replies_due[0];
            replies_due.delete(0);
            if (found !== e.found) report("found", 32'(e.found), 32'(found));
            if (victim !== e.victim) report("victim_frame", 32'(e.victim), 32'(victim));
            if (count !== e.count) report("entry_count", 32'(e.count), 32'(count));
        endfunction

        function logic [lrufr_pkg::FRAME_W-1:0] pick_listed();
            int unsigned                   start;
            logic [lrufr_pkg::FRAME_W-1:0] idx;
            start = $urandom_range(0, lrufr_pkg::FRAME_SPAN - 1);
            for (int i = 0; i < lrufr_pkg::FRAME_SPAN; i++) begin
                idx = lrufr_pkg::FRAME_W'(start + 32'(i));
                if (listed[idx]) return idx;
            end
            return lrufr_pkg::FRAME_W'(start);
        endfunction
    endclass

    logic                             i_clk          = 1'b0;
    logic                             i_rst_n        = 1'b0;
    logic                             i_in_valid     = 1'b0;
    logic                             o_in_stall;
    logic [lrufr_pkg::KIND_W-1:0]     i_kind         = '0;
    logic [lrufr_pkg::FRAME_W-1:0]    i_frame        = '0;
    logic                             o_out_valid;
    logic                             i_out_stall    = 1'b0;
    logic                             o_found;
    logic [lrufr_pkg::FRAME_W-1:0]    o_victim_frame;
    logic [lrufr_pkg::COUNT_W-1:0]    o_entry_count;
    logic                             psel           = 1'b0;
    logic                             penable        = 1'b0;
    logic                             pwrite         = 1'b0;
    logic [lrufr_pkg::APB_ADDR_W-1:0] paddr          = '0;
    logic [lrufr_pkg::APB_DATA_W-1:0] pwdata         = '0;
    logic [lrufr_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    bit                               idle_on        = 1'b0;
    int                               stall_left     = 0;
    lru_list_tracker                  tracker        = new();

    lru_frame_replacer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_frame        (i_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_victim_frame (o_victim_frame),
        .o_entry_count  (o_entry_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                tracker.check_reply(o_found, o_victim_frame, o_entry_count);
            end
            if (i_in_valid && !o_in_stall) tracker.note_request(i_kind, i_frame);
        end
    end

    task automatic send_request(input lrufr_pkg::t_kind kind,
                                input logic [lrufr_pkg::FRAME_W-1:0] f);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_frame    <= f;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        @(negedge i_clk);
    endtask

    task automatic send_random(input int unpin_pct);
        int unsigned                   r;
        lrufr_pkg::t_kind              kind;
        logic [lrufr_pkg::FRAME_W-1:0] f;
        r = $urandom_range(0, 99);
        f = lrufr_pkg::FRAME_W'($urandom_range(0, lrufr_pkg::FRAME_SPAN - 1));
        if (r < unpin_pct) begin
            kind = lrufr_pkg::KIND_UNPIN;
            if ($urandom_range(0, 9) == 0) f = tracker.pick_listed();
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                kind = lrufr_pkg::KIND_PIN;
                if ($urandom_range(0, 9) < 7) f = tracker.pick_listed();
            end else if (r < 95) begin
                kind = lrufr_pkg::KIND_VICTIM;
            end else begin
                kind = KIND_UNUSED;
            end
        end
        send_request(kind, f);
    endtask

    task automatic write_limit(input logic [lrufr_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lrufr_pkg::ADDR_FRAME_LIMIT;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (value & 32'h7f)) tracker.report("frame_limit readback",
                                                        value & 32'h7f, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.limit = value & 32'h7f;
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    initial begin
        int limits     [NUM_PHASES];
        int unpin_mix  [NUM_PHASES];
        int phase_len  [NUM_PHASES];

        limits    = '{64, 5, 1, 0, 127, 33, 0, 64};
        unpin_mix = '{80, 60, 55, 55, 80, 65, 60, 70};
        phase_len = '{230, 200, 200, 180, 230, 220, 220, 220};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_on = 1'b1;
        send_request(lrufr_pkg::KIND_VICTIM, 6'd0);
        send_request(lrufr_pkg::KIND_PIN, 6'd5);
        send_request(KIND_UNUSED, 6'd0);
        send_request(lrufr_pkg::KIND_UNPIN, 6'd0);
        send_request(lrufr_pkg::KIND_UNPIN, 6'd63);
        send_request(lrufr_pkg::KIND_UNPIN, 6'd63);
        send_request(lrufr_pkg::KIND_UNPIN, 6'd21);
        send_request(lrufr_pkg::KIND_UNPIN, 6'd42);
        send_request(lrufr_pkg::KIND_PIN, 6'd63);
        send_request(lrufr_pkg::KIND_PIN, 6'd42);
        send_request(lrufr_pkg::KIND_PIN, 6'd0);
        send_request(lrufr_pkg::KIND_VICTIM, 6'd63);
        send_request(lrufr_pkg::KIND_VICTIM, 6'd0);
        send_request(KIND_UNUSED, 6'd63);
        send_request(lrufr_pkg::KIND_UNPIN, 6'd63);
        send_request(lrufr_pkg::KIND_PIN, 6'd63);
        send_request(lrufr_pkg::KIND_UNPIN, 6'd1);
        send_request(lrufr_pkg::KIND_UNPIN, 6'd2);
        send_request(lrufr_pkg::KIND_VICTIM, 6'd42);
        send_request(lrufr_pkg::KIND_VICTIM, 6'd21);

        limits[6] = $urandom_range(1, 64);
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                i_in_valid <= 1'b0;
                wait_drained();
                write_limit(limits[p]);
            end
            for (int n = 0; n < phase_len[p]; n++) begin
                if (n % 50 == 0) idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                send_random(unpin_mix[p]);
            end
        end
        i_in_valid <= 1'b0;
        idle_on = 1'b0;
        wait_drained();

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("lru_frame_replacer verification clean");
        end else begin
            $display("lru_frame_replacer verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("lru_frame_replacer verification failed");
        $finish;
    end
endmodule
